// File: hw/rtl/running_least_squares_line_fit_top_macros.svh
// Assertion macros for the line fit block.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef RUNNING_LEAST_SQUARES_LINE_FIT_TOP_MACROS_SVH
`define RUNNING_LEAST_SQUARES_LINE_FIT_TOP_MACROS_SVH

// same-cycle implication
`define RLSLF_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("rlslf: same-cycle check failed");

// next-cycle implication
`define RLSLF_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rlslf: next-cycle check failed");

`endif

// File: hw/rtl/rlslf_pkg.sv
// Shared types and constants of the line fit block.
// No dependencies; every other file but the macro header imports it.
package rlslf_pkg;

	localparam int TICK_W  = 64;   // raw tick reading
	localparam int NS_W    = 63;   // reference ns reading
	localparam int SHIFT_W = 6;
	localparam logic [SHIFT_W-1:0] SHIFT_RST = 6'd20;
	localparam int RES_W   = 48;   // slope / intercept fields
	localparam int CNT_W   = 17;   // point_count field
	localparam int FRAC_W  = 32;   // slope fraction bits
	localparam int OP_W    = 64;   // multiplier operand
	localparam int LIMB_W  = 32;   // multiplier limb
	localparam int WIDE_W  = 128;  // products, divisor, dividend

	typedef enum logic [1:0] {
		FIT_OK   = 2'd0,
		FIT_NONE = 2'd1,
		FIT_OVF  = 2'd2
	} fit_status_t;

	typedef enum logic [2:0] {
		MS_PT_XX,
		MS_PT_XY,
		MS_N_XX,
		MS_X_X,
		MS_N_XY,
		MS_X_Y,
		MS_XX_Y,
		MS_X_XY
	} mul_sel_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SET_BASE,
		OP_DIFF,
		OP_SHIFT,
		OP_SET_OVF,
		OP_ACC_XX,
		OP_ACC_XY,
		OP_SAVE_W,
		OP_MAKE_DEN,
		OP_MAG_SLOPE,
		OP_MAG_ICPT,
		OP_SAVE_SLOPE,
		OP_SAVE_ICPT,
		OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t   op;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     div_start;
	} dp_cmd_t;

	typedef struct packed {
		logic have_base;
		logic ovf;
		logic full;
		logic neg;
		logic wide;
		logic den_ok;
		logic mul_busy;
		logic div_busy;
	} dp_status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_EVAL,
		S_SHIFT,
		S_CHECK,
		S_PXX_W,
		S_PXY_W,
		S_FIT,
		S_M1,
		S_M2,
		S_M2B,
		S_M3,
		S_M4,
		S_D1S,
		S_D1_W,
		S_M5,
		S_M6,
		S_D2S,
		S_D2_W,
		S_DONE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_PRE,
		DV_ITER,
		DV_ROUND
	} div_state_t;

endpackage

// File: hw/rtl/rlslf_if.sv
// Valid/ready channel interfaces: timestamp pair in, fit result out.
// Depends on rlslf_pkg.
interface rlslf_sample_if import rlslf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] tick_count;
	logic [NS_W-1:0]   ref_time_ns;

	modport source (output valid, output tick_count, output ref_time_ns, input ready);
	modport sink (input valid, input tick_count, input ref_time_ns, output ready);
endinterface

interface rlslf_fit_if import rlslf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [RES_W-1:0] slope;
	logic signed [RES_W-1:0] intercept;
	logic [1:0]              fit_status;
	logic [CNT_W-1:0]        point_count;

	modport source (output valid, output slope, output intercept, output fit_status,
		output point_count, input ready);
	modport sink (input valid, input slope, input intercept, input fit_status,
		input point_count, output ready);
endinterface

// File: hw/rtl/rlslf_mul.sv
// 64x64 unsigned multiplier, four 32x32 partial products summed in turn.
// Depends on rlslf_pkg.
module rlslf_mul import rlslf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [OP_W-1:0]   a,
	input  logic [OP_W-1:0]   b,
	output logic              busy,
	output logic [WIDE_W-1:0] prod
);

	logic [OP_W-1:0]     a_q, b_q;
	logic [2*LIMB_W-1:0] pp_q;
	logic [1:0]          sh_q;
	logic                pp_vld_q;
	logic [2:0]          ph_q;
	logic                busy_q;
	logic [WIDE_W-1:0]   prod_q;
	logic [LIMB_W-1:0]   a_limb, b_limb;

	// phase bit 1 picks the limb of a, bit 0 the limb of b
	assign a_limb = ph_q[1] ? a_q[OP_W-1:LIMB_W] : a_q[LIMB_W-1:0];
	assign b_limb = ph_q[0] ? b_q[OP_W-1:LIMB_W] : b_q[LIMB_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ph_q     <= '0;
			pp_vld_q <= 1'b0;
		end else if (start) begin
			busy_q   <= 1'b1;
			ph_q     <= '0;
			pp_vld_q <= 1'b0;
		end else if (busy_q) begin
			ph_q     <= ph_q + 3'd1;
			pp_vld_q <= !ph_q[2];
			if (ph_q[2]) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			b_q    <= b;
			prod_q <= '0;
		end else if (busy_q) begin
			if (!ph_q[2]) begin
				pp_q <= (2*LIMB_W)'(a_limb) * (2*LIMB_W)'(b_limb);
				sh_q <= {1'b0, ph_q[1]} + {1'b0, ph_q[0]};
			end
			if (pp_vld_q) begin
				prod_q <= prod_q + (WIDE_W'(pp_q) << (LIMB_W * sh_q));
			end
		end
	end

	assign busy = busy_q;
	assign prod = prod_q;

endmodule

// File: hw/rtl/rlslf_div.sv
// Restoring divider: 48 quotient bits, one per cycle, round half up on the
// remainder, plus an up-front check for a quotient of 2^48 or more.
// Depends on rlslf_pkg.
module rlslf_div import rlslf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDE_W-1:0] num,
	input  logic [WIDE_W-1:0] den,
	output logic              busy,
	output logic              big,
	output logic [RES_W:0]    quot
);

	localparam int CW = $clog2(RES_W);

	div_state_t        st_q, st_d;
	logic [CW-1:0]     cnt_q;
	logic [WIDE_W-1:0] den_q, rem_q;
	logic [RES_W-1:0]  lo_q;
	logic [RES_W:0]    q_q;
	logic              big_q;
	logic [WIDE_W:0]   rem_sh, trial;
	logic              pre_big, round_up;

	assign rem_sh   = {rem_q, lo_q[RES_W-1]};
	assign trial    = rem_sh - {1'b0, den_q};   // top bit set: rem_sh below den
	assign pre_big  = rem_q >= den_q;
	assign round_up = {rem_q, 1'b0} >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= DV_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == DV_PRE) begin
				cnt_q <= CW'(RES_W - 1);
			end else if (st_q == DV_ITER) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			DV_IDLE:  if (start) st_d = DV_PRE;
			DV_PRE:   st_d = pre_big ? DV_IDLE : DV_ITER;
			DV_ITER:  if (cnt_q == '0) st_d = DV_ROUND;
			DV_ROUND: st_d = DV_IDLE;
			default:  st_d = DV_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start && st_q == DV_IDLE) begin
			// high part of the dividend is the starting remainder
			rem_q <= WIDE_W'(num[WIDE_W-1:RES_W]);
			lo_q  <= num[RES_W-1:0];
			den_q <= den;
		end else begin
			case (st_q)
				DV_PRE: begin
					big_q <= pre_big;
					q_q   <= '0;
				end
				DV_ITER: begin
					if (!trial[WIDE_W]) begin
						rem_q <= trial[WIDE_W-1:0];
					end else begin
						rem_q <= rem_sh[WIDE_W-1:0];
					end
					q_q  <= {q_q[RES_W-1:0], !trial[WIDE_W]};
					lo_q <= {lo_q[RES_W-2:0], 1'b0};
				end
				DV_ROUND: begin
					if (round_up) begin
						q_q <= q_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign busy = st_q != DV_IDLE;
	assign big  = big_q;
	assign quot = q_q;

endmodule

// File: hw/rtl/rlslf_dp.sv
// Datapath: base and running sums, difference checks, fit terms, result register.
// Depends on rlslf_pkg, rlslf_mul, rlslf_div.
module rlslf_dp import rlslf_pkg::*; #(
	parameter int DIFF_BITS       = 24,
	parameter int MAX_POINTS_LOG2 = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_status_t         sts,
	input  logic               cfg_wr_en,
	input  logic [SHIFT_W-1:0] cfg_wr_data,
	input  logic [TICK_W-1:0]  tick_count,
	input  logic [NS_W-1:0]    ref_time_ns,
	output logic [RES_W-1:0]   slope,
	output logic [RES_W-1:0]   intercept,
	output fit_status_t        fit_status,
	output logic [CNT_W-1:0]   point_count
);

	localparam int XW = DIFF_BITS;
	localparam int ML = MAX_POINTS_LOG2;
	localparam int NW = ML + 1;
	localparam int SW = XW + ML;
	localparam int QW = 2 * XW + ML;

	logic [SHIFT_W-1:0] shift_q;
	logic [TICK_W-1:0]  tick_q, base_tick_q, dt_q;
	logic [NS_W-1:0]    ns_q, base_ns_q, dn_q;
	logic               have_base_q, ovf_q, neg_q, wide_q;
	logic [NW-1:0]      pts_q;
	logic [SW-1:0]      acc_x_q, acc_y_q;
	logic [QW-1:0]      acc_xx_q, acc_xy_q;
	logic [XW-1:0]      x_q, y_q;
	logic [WIDE_W-1:0]  w1_q, den_q, mag_q;
	logic               sign_q, den_ok_q;
	logic [RES_W-1:0]   slope_q, icpt_q;
	logic [RES_W-1:0]   res_slope_q, res_icpt_q;
	fit_status_t        res_status_q;
	logic [CNT_W-1:0]   res_pts_q;

	logic [OP_W-1:0]    mul_a, mul_b;
	logic               mul_busy;
	logic [WIDE_W-1:0]  mul_prod;
	logic               div_busy, div_big;
	logic [RES_W:0]     div_quot;

	logic [TICK_W:0]    dt_full;
	logic [NS_W:0]      dn_full;
	logic [NS_W-1:0]    xs;
	logic [TICK_W-1:0]  ys;
	logic [WIDE_W:0]    w_diff;
	logic [WIDE_W-1:0]  w_alt, w_abs;

	function automatic logic [RES_W-1:0] clamp_q(input logic bg, input logic ng,
			input logic [RES_W:0] q);
		logic [RES_W:0] lim;
		logic [RES_W:0] m;
		lim = ((RES_W+1)'(1) << (RES_W - 1)) - (ng ? (RES_W+1)'(0) : (RES_W+1)'(1));
		m = (bg || q > lim) ? lim : q;
		clamp_q = ng ? RES_W'(-m) : m[RES_W-1:0];
	endfunction

	always_comb begin
		mul_a = OP_W'(x_q);
		mul_b = OP_W'(x_q);
		case (cmd.mul_sel)
			MS_PT_XX: begin mul_a = OP_W'(x_q);      mul_b = OP_W'(x_q);      end
			MS_PT_XY: begin mul_a = OP_W'(x_q);      mul_b = OP_W'(y_q);      end
			MS_N_XX:  begin mul_a = OP_W'(pts_q);    mul_b = OP_W'(acc_xx_q); end
			MS_X_X:   begin mul_a = OP_W'(acc_x_q);  mul_b = OP_W'(acc_x_q);  end
			MS_N_XY:  begin mul_a = OP_W'(pts_q);    mul_b = OP_W'(acc_xy_q); end
			MS_X_Y:   begin mul_a = OP_W'(acc_x_q);  mul_b = OP_W'(acc_y_q);  end
			MS_XX_Y:  begin mul_a = OP_W'(acc_xx_q); mul_b = OP_W'(acc_y_q);  end
			MS_X_XY:  begin mul_a = OP_W'(acc_x_q);  mul_b = OP_W'(acc_xy_q); end
			default:  ;
		endcase
	end

	rlslf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	rlslf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (mag_q),
		.den    (den_q),
		.busy   (div_busy),
		.big    (div_big),
		.quot   (div_quot)
	);

	assign dt_full = {1'b0, tick_q} - {1'b0, base_tick_q};
	assign dn_full = {1'b0, ns_q} - {1'b0, base_ns_q};
	assign xs      = dn_q >> shift_q;
	assign ys      = dt_q >> shift_q;
	// signed difference of the held term and the fresh product
	assign w_diff  = {1'b0, w1_q} - {1'b0, mul_prod};
	assign w_alt   = mul_prod - w1_q;
	assign w_abs   = w_diff[WIDE_W] ? w_alt : w_diff[WIDE_W-1:0];

	// model state and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= SHIFT_RST;
			have_base_q <= 1'b0;
			ovf_q       <= 1'b0;
			pts_q       <= '0;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			acc_xx_q    <= '0;
			acc_xy_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				shift_q <= cfg_wr_data;
			end
			unique case (cmd.op)
				OP_SET_BASE: begin
					have_base_q <= 1'b1;
					pts_q       <= NW'(1);
				end
				OP_SET_OVF: ovf_q <= 1'b1;
				OP_ACC_XX:  acc_xx_q <= acc_xx_q + mul_prod[QW-1:0];
				OP_ACC_XY: begin
					acc_xy_q <= acc_xy_q + mul_prod[QW-1:0];
					acc_x_q  <= acc_x_q + SW'(x_q);
					acc_y_q  <= acc_y_q + SW'(y_q);
					pts_q    <= pts_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				tick_q <= tick_count;
				ns_q   <= ref_time_ns;
			end
			OP_SET_BASE: begin
				base_tick_q <= tick_q;
				base_ns_q   <= ns_q;
			end
			OP_DIFF: begin
				dt_q  <= dt_full[TICK_W-1:0];
				dn_q  <= dn_full[NS_W-1:0];
				neg_q <= dt_full[TICK_W] | dn_full[NS_W];
			end
			OP_SHIFT: begin
				x_q    <= xs[XW-1:0];
				y_q    <= ys[XW-1:0];
				wide_q <= (|xs[NS_W-1:XW]) | (|ys[TICK_W-1:XW]);
			end
			OP_SAVE_W: w1_q <= mul_prod;
			OP_MAKE_DEN: begin
				den_q    <= w_diff[WIDE_W-1:0];
				den_ok_q <= !w_diff[WIDE_W] && (w_diff[WIDE_W-1:0] != '0);
			end
			OP_MAG_SLOPE: begin
				mag_q  <= w_abs << FRAC_W;
				sign_q <= w_diff[WIDE_W];
			end
			OP_MAG_ICPT: begin
				mag_q  <= w_abs;
				sign_q <= w_diff[WIDE_W];
			end
			OP_SAVE_SLOPE: slope_q <= clamp_q(div_big, sign_q, div_quot);
			OP_SAVE_ICPT:  icpt_q  <= clamp_q(div_big, sign_q, div_quot);
			OP_PUBLISH: begin
				res_pts_q <= CNT_W'(pts_q);
				if (ovf_q) begin
					res_status_q <= FIT_OVF;
				end else if (den_ok_q) begin
					res_status_q <= FIT_OK;
				end else begin
					res_status_q <= FIT_NONE;
				end
				res_slope_q <= (!ovf_q && den_ok_q) ? slope_q : '0;
				res_icpt_q  <= (!ovf_q && den_ok_q) ? icpt_q : '0;
			end
			default: ;
		endcase
	end

	assign sts.have_base = have_base_q;
	assign sts.ovf       = ovf_q;
	assign sts.full      = pts_q[ML];
	assign sts.neg       = neg_q;
	assign sts.wide      = wide_q;
	assign sts.den_ok    = den_ok_q;
	assign sts.mul_busy  = mul_busy;
	assign sts.div_busy  = div_busy;

	assign slope       = res_slope_q;
	assign intercept   = res_icpt_q;
	assign fit_status  = res_status_q;
	assign point_count = res_pts_q;

endmodule

// File: hw/rtl/rlslf_ctrl.sv
// Sequencer: steps one request through checks, accumulation, fit terms and divisions.
// Depends on rlslf_pkg.
module rlslf_ctrl import rlslf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output dp_cmd_t    cmd,
	input  dp_status_t sts
);

	ctrl_state_t st_q, st_d;
	logic        out_valid_q;
	logic        publish;

	assign publish = cmd.op == OP_PUBLISH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st_d          = st_q;
		in_ready      = 1'b0;
		cmd.op        = OP_NONE;
		cmd.mul_start = 1'b0;
		cmd.mul_sel   = MS_PT_XX;
		cmd.div_start = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					st_d   = S_EVAL;
				end
			end
			S_EVAL: begin
				if (!sts.have_base) begin
					cmd.op = OP_SET_BASE;
					st_d   = S_FIT;
				end else if (sts.ovf || sts.full) begin
					st_d = S_FIT;   // report current sums again
				end else begin
					cmd.op = OP_DIFF;
					st_d   = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.op = OP_SHIFT;
				st_d   = S_CHECK;
			end
			S_CHECK: begin
				if (sts.neg || sts.wide) begin
					cmd.op = OP_SET_OVF;
					st_d   = S_FIT;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_PT_XX;
					st_d          = S_PXX_W;
				end
			end
			S_PXX_W: begin
				if (!sts.mul_busy) begin
					cmd.op        = OP_ACC_XX;
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_PT_XY;
					st_d          = S_PXY_W;
				end
			end
			S_PXY_W: begin
				if (!sts.mul_busy) begin
					cmd.op = OP_ACC_XY;
					st_d   = S_FIT;
				end
			end
			S_FIT: begin
				if (sts.ovf) begin
					st_d = S_DONE;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_N_XX;
					st_d          = S_M1;
				end
			end
			S_M1: begin
				if (!sts.mul_busy) begin
					cmd.op        = OP_SAVE_W;
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_X_X;
					st_d          = S_M2;
				end
			end
			S_M2: begin
				if (!sts.mul_busy) begin
					cmd.op = OP_MAKE_DEN;
					st_d   = S_M2B;
				end
			end
			S_M2B: begin
				if (!sts.den_ok) begin
					st_d = S_DONE;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_N_XY;
					st_d          = S_M3;
				end
			end
			S_M3: begin
				if (!sts.mul_busy) begin
					cmd.op        = OP_SAVE_W;
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_X_Y;
					st_d          = S_M4;
				end
			end
			S_M4: begin
				if (!sts.mul_busy) begin
					cmd.op = OP_MAG_SLOPE;
					st_d   = S_D1S;
				end
			end
			S_D1S: begin
				// first intercept product runs alongside the slope division
				cmd.div_start = 1'b1;
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MS_XX_Y;
				st_d          = S_D1_W;
			end
			S_D1_W: begin
				if (!sts.div_busy) begin
					cmd.op = OP_SAVE_SLOPE;
					st_d   = S_M5;
				end
			end
			S_M5: begin
				if (!sts.mul_busy) begin
					cmd.op        = OP_SAVE_W;
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_X_XY;
					st_d          = S_M6;
				end
			end
			S_M6: begin
				if (!sts.mul_busy) begin
					cmd.op = OP_MAG_ICPT;
					st_d   = S_D2S;
				end
			end
			S_D2S: begin
				cmd.div_start = 1'b1;
				st_d          = S_D2_W;
			end
			S_D2_W: begin
				if (!sts.div_busy) begin
					cmd.op = OP_SAVE_ICPT;
					st_d   = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.op = OP_PUBLISH;
					st_d   = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: hw/rtl/running_least_squares_line_fit_top.sv
// Running least-squares fit of tick counter against reference ns. One request
// (tick, ns pair) is worked at a time and gives one result. A full fit takes two
// 48-step divisions (one quotient bit per cycle in a single shared divider) and
// eight 64x64 products from one 32x32 multiplier. An accumulated request that
// finds no fit, the base request, one that sets overflow and one after overflow
// take shorter paths, each plus any wait for the output. A new request is taken
// while the last result still waits on the output. diff_shift may be rewritten
// only when idle.
module running_least_squares_line_fit_top import rlslf_pkg::*; #(
	parameter int DIFF_BITS       = 24,
	parameter int MAX_POINTS_LOG2 = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [SHIFT_W-1:0] cfg_wr_data,
	rlslf_sample_if.sink       sample,
	rlslf_fit_if.source        fit
);

	`include "running_least_squares_line_fit_top_macros.svh"

	dp_cmd_t          dp_cmd;
	dp_status_t       dp_sts;
	logic [RES_W-1:0] dp_slope, dp_icpt;
	fit_status_t      dp_fit_status;
	logic [CNT_W-1:0] dp_pts;

	rlslf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (fit.valid),
		.out_ready (fit.ready),
		.cmd       (dp_cmd),
		.sts       (dp_sts)
	);

	rlslf_dp #(
		.DIFF_BITS       (DIFF_BITS),
		.MAX_POINTS_LOG2 (MAX_POINTS_LOG2)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.sts         (dp_sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.tick_count  (sample.tick_count),
		.ref_time_ns (sample.ref_time_ns),
		.slope       (dp_slope),
		.intercept   (dp_icpt),
		.fit_status  (dp_fit_status),
		.point_count (dp_pts)
	);

	assign fit.slope       = dp_slope;
	assign fit.intercept   = dp_icpt;
	assign fit.fit_status  = dp_fit_status;
	assign fit.point_count = dp_pts;

	// no request is taken while an arithmetic unit is still running
	`RLSLF_ASSERT_IMP(a_ready_units_idle, sample.ready, !dp_sts.mul_busy && !dp_sts.div_busy)
	// overflow is only cleared by reset
	`RLSLF_ASSERT_NEXT(a_ovf_sticky, dp_sts.ovf, dp_sts.ovf)
	`RLSLF_ASSERT_IMP(a_nofit_zero, fit.valid && fit.fit_status != FIT_OK, fit.slope == '0 && fit.intercept == '0)
	`RLSLF_ASSERT_IMP(a_pts_limit, fit.valid, fit.point_count <= (CNT_W'(1) << MAX_POINTS_LOG2))

endmodule
